// ===== rtl/fec_pkg.sv =====
// Shared types and constants of the feedback echo comb.
`timescale 1ns / 1ps

package fec_pkg;

	// Field widths of the sample stream
	localparam int SAMPLE_W = 8;
	localparam int DELAY_W  = 12;
	localparam int SEEN_W   = 12;

	// Saturation point of the per-channel sample counter
	localparam logic [SEEN_W-1:0] SEEN_MAX = 12'hFFF;

	// Reset value of the echo distance register
	localparam logic [DELAY_W-1:0] DELAY_RESET = 12'd1;

	// Mixer: 0.3 in Q0.16, offset folds the -128 bias, +128 midscale and rounding
	localparam int               MIX_W      = 24;
	localparam logic [MIX_W-1:0] GAIN_Q16   = 24'd19661;
	localparam logic [MIX_W-1:0] MIX_OFFSET = 24'd3388160;

	// Per-sample control decided at the front end
	typedef struct packed {
		logic pass;   // still inside the first D samples of the buffer
		logic dzero;  // zero echo distance: the input is its own echo
	} fec_ctl_t;

endpackage

// ===== rtl/fec_if.sv =====
// Channel interfaces: sample input, result output and configuration write.
`timescale 1ns / 1ps

interface fec_in_if;
	logic                         valid;
	logic                         ready;
	logic [fec_pkg::SAMPLE_W-1:0] sample_in;
	logic                         channel;
	logic                         start_of_buffer;

	modport source (output valid, output sample_in, output channel,
		output start_of_buffer, input ready);
	modport sink (input valid, input sample_in, input channel,
		input start_of_buffer, output ready);
endinterface

interface fec_out_if;
	logic                         valid;
	logic                         ready;
	logic [fec_pkg::SAMPLE_W-1:0] sample_out;
	logic                         channel_out;

	modport source (output valid, output sample_out, output channel_out, input ready);
	modport sink (input valid, input sample_out, input channel_out, output ready);
endinterface

interface fec_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [fec_pkg::DELAY_W-1:0] echo_delay;

	modport source (output valid, output echo_delay, input ready);
	modport sink (input valid, input echo_delay, output ready);
endinterface

// ===== rtl/feedback_echo_comb.sv =====
// Top level of the per-channel feedback comb echo.
//
//  channel  | dir | handshake      | payload
//  samples  | in  | valid / ready  | sample_in[7:0], channel, start_of_buffer
//  results  | out | valid / ready  | sample_out[7:0], channel_out
//  cfg      | in  | valid / ready  | echo_delay[11:0] (ready always high)
//
// One sample per cycle sustained while results are taken; an accepted transaction
// passes the mix stage register and then the output register before its result is valid
// (delay-line read, then mix into the output register).
// The single delay-line RAM port pair (one read, one write per cycle) sets the rate;
// a result written in the same cycle as a dependent read is forwarded.
// arst_n clears pointers, counters and valids; delay-line contents stay undefined.
// A stalled output holds the mix stage, and input ready drops only then.
`timescale 1ns / 1ps

module feedback_echo_comb #(
	parameter int MAX_DELAY = 4096
) (
	input  logic      clk,
	input  logic      arst_n,
	fec_in_if.sink    samples,
	fec_out_if.source results,
	fec_cfg_if.sink   cfg
);

	localparam int AW    = $clog2(MAX_DELAY);
	localparam int RAM_D = 2 * (2 ** AW);

	logic [fec_pkg::DELAY_W-1:0]  echo_delay_q;

	logic                         in_acc;
	logic                         advance;
	logic [AW-1:0]                rd_addr;
	logic [AW-1:0]                wr_addr;
	fec_pkg::fec_ctl_t            ctl;
	logic [AW:0]                  rd_full;
	logic [AW:0]                  wr_full;

	logic                         s1_valid_q;
	logic [fec_pkg::SAMPLE_W-1:0] sample_s1;
	logic                         channel_s1;
	fec_pkg::fec_ctl_t            ctl_s1;
	logic [AW:0]                  waddr_s1;
	logic                         fwd_s1;

	logic [fec_pkg::SAMPLE_W-1:0] ram_rdata;
	logic [fec_pkg::SAMPLE_W-1:0] yd;
	logic [fec_pkg::SAMPLE_W-1:0] y;
	logic [fec_pkg::SAMPLE_W-1:0] y_fwd_q;

	logic                         out_valid_q;
	logic [fec_pkg::SAMPLE_W-1:0] sample_out_q;
	logic                         channel_out_q;

	// Configuration register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_delay_q <= fec_pkg::DELAY_RESET;
		end else if (cfg.valid) begin
			echo_delay_q <= cfg.echo_delay;
		end
	end

	// Handshake: mix stage moves when the output register is free or drains
	assign advance       = s1_valid_q && (!out_valid_q || results.ready);
	assign samples.ready = !s1_valid_q || advance;
	assign in_acc        = samples.valid && samples.ready;

	fec_front #(
		.MAX_DELAY (MAX_DELAY)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.acc             (in_acc),
		.channel         (samples.channel),
		.start_of_buffer (samples.start_of_buffer),
		.echo_delay      (echo_delay_q),
		.rd_addr         (rd_addr),
		.wr_addr         (wr_addr),
		.ctl             (ctl)
	);

	assign rd_full = {samples.channel, rd_addr};
	assign wr_full = {samples.channel, wr_addr};

	// Delay line, both channels in one RAM, channel as the top address bit
	fec_ram #(
		.WIDTH (fec_pkg::SAMPLE_W),
		.DEPTH (RAM_D)
	) u_ram (
		.clk   (clk),
		.we    (advance),
		.waddr (waddr_s1),
		.wdata (y),
		.re    (in_acc),
		.raddr (rd_full),
		.rdata (ram_rdata)
	);

	// Mix stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Mix stage payload; forward when the read hits the entry written this edge
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_s1  <= samples.sample_in;
			channel_s1 <= samples.channel;
			ctl_s1     <= ctl;
			waddr_s1   <= wr_full;
			fwd_s1     <= advance && (rd_full == waddr_s1);
		end
		if (advance) begin
			y_fwd_q <= y;
		end
	end

	// Echo source select
	always_comb begin
		if (ctl_s1.dzero) begin
			yd = sample_s1;
		end else if (fwd_s1) begin
			yd = y_fwd_q;
		end else begin
			yd = ram_rdata;
		end
	end

	fec_mix u_mix (
		.x    (sample_s1),
		.yd   (yd),
		.pass (ctl_s1.pass),
		.y    (y)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sample_out_q  <= y;
			channel_out_q <= channel_s1;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.sample_out  = sample_out_q;
	assign results.channel_out = channel_out_q;

endmodule

// ===== rtl/fec_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fec_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/fec_front.sv =====
// Front end: per-channel write pointers, sample counters and delay-line read address.
`timescale 1ns / 1ps

module fec_front #(
	parameter int MAX_DELAY = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                acc,
	input  logic                                channel,
	input  logic                                start_of_buffer,
	input  logic [fec_pkg::DELAY_W-1:0]         echo_delay,
	output logic [$clog2(MAX_DELAY)-1:0]        rd_addr,
	output logic [$clog2(MAX_DELAY)-1:0]        wr_addr,
	output fec_pkg::fec_ctl_t                   ctl
);

	localparam int AW = $clog2(MAX_DELAY);
	localparam int SW = ((AW > fec_pkg::DELAY_W) ? AW : fec_pkg::DELAY_W) + 1;

	logic [AW-1:0]              wp_q   [2];
	logic [fec_pkg::SEEN_W-1:0] seen_q [2];

	logic [AW-1:0]              wp_cur;
	logic [AW-1:0]              wp_nxt;
	logic [fec_pkg::SEEN_W-1:0] seen_eff;
	logic [fec_pkg::SEEN_W-1:0] seen_nxt;
	logic [SW-1:0]              d_ext;
	logic [SW-1:0]              d_clamp;
	logic [SW-1:0]              wp_ext;
	logic [SW-1:0]              rd_full;

	// Echo distance, clamped to the delay-line length
	always_comb begin
		d_ext   = SW'(echo_delay);
		d_clamp = (d_ext > SW'(MAX_DELAY)) ? SW'(MAX_DELAY) : d_ext;
	end

	// Read address wp - D modulo the line length
	always_comb begin
		wp_cur = wp_q[channel];
		wp_ext = SW'(wp_cur);
		if (wp_ext >= d_clamp) begin
			rd_full = wp_ext - d_clamp;
		end else begin
			rd_full = wp_ext + SW'(MAX_DELAY) - d_clamp;
		end
		rd_addr = rd_full[AW-1:0];
		wr_addr = wp_cur;
		wp_nxt  = (wp_cur == AW'(MAX_DELAY - 1)) ? '0 : wp_cur + 1'b1;
	end

	// Passthrough decision; start of buffer restarts the count at this sample
	always_comb begin
		seen_eff  = start_of_buffer ? '0 : seen_q[channel];
		ctl.pass  = SW'(seen_eff) < d_clamp;
		ctl.dzero = (d_clamp == '0);
		seen_nxt  = (seen_eff < fec_pkg::SEEN_MAX) ? seen_eff + 1'b1 : seen_eff;
	end

	// Per-channel state advances on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q[0]   <= '0;
			wp_q[1]   <= '0;
			seen_q[0] <= '0;
			seen_q[1] <= '0;
		end else if (acc) begin
			wp_q[channel]   <= wp_nxt;
			seen_q[channel] <= seen_nxt;
		end
	end

endmodule

// ===== rtl/fec_mix.sv =====
// Echo mixer: 0.3*(x-128) + 0.3*(echo-128) + 128, rounded half up, or passthrough.
`timescale 1ns / 1ps

module fec_mix (
	input  logic [fec_pkg::SAMPLE_W-1:0] x,
	input  logic [fec_pkg::SAMPLE_W-1:0] yd,
	input  logic                         pass,
	output logic [fec_pkg::SAMPLE_W-1:0] y
);

	logic [fec_pkg::SAMPLE_W:0]    sum;
	logic [fec_pkg::MIX_W-1:0]     acc;

	// Sum stays within 13.4M, so the 24-bit accumulator never wraps
	always_comb begin
		sum = {1'b0, x} + {1'b0, yd};
		acc = fec_pkg::MIX_W'(sum) * fec_pkg::GAIN_Q16 + fec_pkg::MIX_OFFSET;
		y   = pass ? x : acc[fec_pkg::MIX_W-1 -: fec_pkg::SAMPLE_W];
	end

endmodule

// ===== rtl/fec_checker.sv =====
// Port-level checker for the feedback echo comb, bound to the top level.
`timescale 1ns / 1ps

module fec_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [fec_pkg::SAMPLE_W-1:0] sample_out,
	input logic                         channel_out
);

	logic [1:0] inflight_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + {1'b0, in_acc} - {1'b0, out_acc};
		end
	end

	// At most the mix stage and the output register hold items
	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q != 2'd3)
		else $error("more than two transactions in flight");

	// No result without a pending input
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != 2'd0)
		else $error("result without an accepted sample");

	// An empty block never refuses input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == 2'd0 |-> in_ready)
		else $error("input stalled while block empty");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(channel_out))
		else $error("stalled result changed");

endmodule

bind feedback_echo_comb fec_checker u_fec_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (samples.valid),
	.in_ready    (samples.ready),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.sample_out  (results.sample_out),
	.channel_out (results.channel_out)
);
